// ===== rtl/mixed_radix_index_convert_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the mixed-radix index converter
// Concurrent property wrappers that compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MIXED_RADIX_INDEX_CONVERT_ASSERT_SVH
`define MIXED_RADIX_INDEX_CONVERT_ASSERT_SVH
`ifndef SYNTH
`define MRIX_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mrix assertion failed");
`define MRIX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mrix assertion failed");
`else
`define MRIX_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MRIX_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/mrix_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed-radix index converter package
// Shared widths, codes and the pipeline item type.
// ----------------------------------------------------------------------------
package mrix_pkg;

   localparam int NUM_REGS    = 4;
   localparam int DIM_BITS    = 12;
   localparam int COORD_W     = DIM_BITS;
   localparam int SIZE_W      = DIM_BITS + 1;
   localparam int OFFSET_W    = 48;
   localparam int STEP_BITS   = 4;
   localparam int DIV_STAGES  = OFFSET_W / STEP_BITS;

   localparam logic [2:0] REG_DIM_COUNT = 3'd0;
   localparam logic [2:0] REG_SIZE_DIM0 = 3'd1;
   localparam logic [2:0] REG_SIZE_DIM1 = 3'd2;
   localparam logic [2:0] REG_SIZE_DIM2 = 3'd3;
   localparam logic [2:0] REG_SIZE_DIM3 = 3'd4;

   localparam logic OP_FLATTEN   = 1'b0;
   localparam logic OP_UNFLATTEN = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_COORD  = 2'd1,
      ERR_OFFSET = 2'd2
   } err_type;

   typedef struct packed {
      logic                             valid;
      logic                             opcode;
      logic                             cerr;
      logic [NUM_REGS-1:0][COORD_W-1:0] coord;
      logic [OFFSET_W-1:0]              acc;
      logic [OFFSET_W-1:0]              work;
      logic [SIZE_W-1:0]                rem;
   } item_type;

endpackage

// ===== rtl/mrix_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring division stage
// Retires STEP_BITS quotient bits of the offset per cycle against one dimension
// size and, at the last stage of a division, stores the remainder.
// ----------------------------------------------------------------------------
module mrix_div_stage #(
   parameter bit FIRST = 1'b0,
   parameter bit LAST  = 1'b0,
   parameter int DIM   = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [mrix_pkg::SIZE_W-1:0]  divisor,
   input  mrix_pkg::item_type           item_i,
   output mrix_pkg::item_type           item_o
);

   mrix_pkg::item_type item_ff;
   mrix_pkg::item_type item_in;

   always_comb begin
      logic [mrix_pkg::SIZE_W-1:0]   r;
      logic [mrix_pkg::SIZE_W:0]     t;
      logic [mrix_pkg::OFFSET_W-1:0] w;
      r = FIRST ? '0 : item_i.rem;
      w = item_i.work;
      for (int i = 0; i < mrix_pkg::STEP_BITS; i++) begin
         t = {r, w[mrix_pkg::OFFSET_W-1]};
         w = {w[mrix_pkg::OFFSET_W-2:0], 1'b0};
         if (t >= {1'b0, divisor}) begin
            t    = t - {1'b0, divisor};
            w[0] = 1'b1;
         end
         r = t[mrix_pkg::SIZE_W-1:0];
      end
      item_in      = item_i;
      item_in.work = w;
      item_in.rem  = r;
      if (LAST) begin
         item_in.coord[DIM] = r[mrix_pkg::COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff <= item_in;
      end
   end

   assign item_o = item_ff;

endmodule

// ===== rtl/mixed_radix_index_convert.sv =====
`timescale 1ns / 1ps
// A result passes through the Horner registers, the division stages and the output register.
// Throughput: one transfer per cycle; busy stays low and start is taken at every edge.
// The depth is set by the three serial divisions, four quotient bits per stage.
// Reset clears every stage valid bit and returns dim_count to 0 and each size to 1.
// The receiver cannot stall, so the pipeline advances in every cycle.
// ----------------------------------------------------------------------------
// Mixed-radix index converter
// Flattens a coordinate to its row-major offset or unflattens an offset back
// into coordinates, within a box whose dimension sizes are configured.
// ----------------------------------------------------------------------------
module mixed_radix_index_convert #(
   parameter int MAX_DIMS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [4:0]                     paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_opcode,
   input  logic [mrix_pkg::COORD_W-1:0]   req_coord_0,
   input  logic [mrix_pkg::COORD_W-1:0]   req_coord_1,
   input  logic [mrix_pkg::COORD_W-1:0]   req_coord_2,
   input  logic [mrix_pkg::COORD_W-1:0]   req_coord_3,
   input  logic [mrix_pkg::OFFSET_W-1:0]  req_offset_in,
   output logic                           rsp_valid,
   output logic [mrix_pkg::OFFSET_W-1:0]  rsp_offset_out,
   output logic [mrix_pkg::COORD_W-1:0]   rsp_out_coord_0,
   output logic [mrix_pkg::COORD_W-1:0]   rsp_out_coord_1,
   output logic [mrix_pkg::COORD_W-1:0]   rsp_out_coord_2,
   output logic [mrix_pkg::COORD_W-1:0]   rsp_out_coord_3,
   output logic [1:0]                     rsp_error_code
);

`include "mixed_radix_index_convert_assert.svh"

   localparam int NREG      = mrix_pkg::NUM_REGS;
   localparam int DIM_LIMIT = (MAX_DIMS < NREG) ? MAX_DIMS : NREG;
   localparam logic [16:0] SIZE_CAP = 17'(1) << mrix_pkg::DIM_BITS;
   localparam int NDIV = (NREG - 1) * mrix_pkg::DIV_STAGES;

   logic [2:0]                  dim_count_ff;
   logic [mrix_pkg::SIZE_W-1:0] size_ff [NREG];
   logic [2:0]                  dims_use;
   logic [mrix_pkg::SIZE_W-1:0] eff [NREG];
   logic                        wr_en;
   logic [2:0]                  reg_idx;

   assign pready  = 1'b1;
   assign busy    = 1'b0;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= 3'd0;
         for (int k = 0; k < NREG; k++) begin
            size_ff[k] <= mrix_pkg::SIZE_W'(1);
         end
      end else if (wr_en) begin
         case (reg_idx)
            mrix_pkg::REG_DIM_COUNT: dim_count_ff <= pwdata[2:0];
            mrix_pkg::REG_SIZE_DIM0: size_ff[0] <= pwdata[mrix_pkg::SIZE_W-1:0];
            mrix_pkg::REG_SIZE_DIM1: size_ff[1] <= pwdata[mrix_pkg::SIZE_W-1:0];
            mrix_pkg::REG_SIZE_DIM2: size_ff[2] <= pwdata[mrix_pkg::SIZE_W-1:0];
            mrix_pkg::REG_SIZE_DIM3: size_ff[3] <= pwdata[mrix_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         mrix_pkg::REG_DIM_COUNT: prdata = {29'd0, dim_count_ff};
         mrix_pkg::REG_SIZE_DIM0: prdata = 32'(size_ff[0]);
         mrix_pkg::REG_SIZE_DIM1: prdata = 32'(size_ff[1]);
         mrix_pkg::REG_SIZE_DIM2: prdata = 32'(size_ff[2]);
         mrix_pkg::REG_SIZE_DIM3: prdata = 32'(size_ff[3]);
         default:                 prdata = 32'd0;
      endcase
   end

   // Dimensions not in use, and sizes of zero, behave as size one; larger sizes are capped at 4096.
   always_comb begin
      dims_use = (32'(dim_count_ff) > DIM_LIMIT) ? 3'(DIM_LIMIT) : dim_count_ff;
      for (int k = 0; k < NREG; k++) begin
         if (3'(k) >= dims_use || size_ff[k] == '0) begin
            eff[k] = mrix_pkg::SIZE_W'(1);
         end else if (17'(size_ff[k]) > SIZE_CAP) begin
            eff[k] = SIZE_CAP[mrix_pkg::SIZE_W-1:0];
         end else begin
            eff[k] = size_ff[k];
         end
      end
   end

   mrix_pkg::item_type hf_ff [NREG];
   mrix_pkg::item_type hf_in [NREG];

   always_comb begin
      hf_in[0].valid  = start && !busy;
      hf_in[0].opcode = req_opcode;
      hf_in[0].coord[0] = (dims_use > 3'd0) ? req_coord_0 : '0;
      hf_in[0].coord[1] = (dims_use > 3'd1) ? req_coord_1 : '0;
      hf_in[0].coord[2] = (dims_use > 3'd2) ? req_coord_2 : '0;
      hf_in[0].coord[3] = (dims_use > 3'd3) ? req_coord_3 : '0;
      hf_in[0].cerr = 1'b0;
      for (int k = 0; k < NREG; k++) begin
         if ({1'b0, hf_in[0].coord[k]} >= eff[k]) begin
            hf_in[0].cerr = 1'b1;
         end
      end
      hf_in[0].acc  = mrix_pkg::OFFSET_W'(hf_in[0].coord[0]);
      hf_in[0].work = req_offset_in;
      hf_in[0].rem  = '0;
   end

   // Horner steps: acc = acc * size + coordinate, one dimension per stage.
   for (genvar k = 1; k < NREG; k++) begin : g_horner
      always_comb begin
         hf_in[k]     = hf_ff[k-1];
         hf_in[k].acc = mrix_pkg::OFFSET_W'(hf_ff[k-1].acc * eff[k])
                        + mrix_pkg::OFFSET_W'(hf_ff[k-1].coord[k]);
      end
   end

   for (genvar k = 0; k < NREG; k++) begin : g_hreg
      always_ff @(posedge clock) begin
         if (reset) begin
            hf_ff[k].valid <= 1'b0;
         end else begin
            hf_ff[k] <= hf_in[k];
         end
      end
   end

   mrix_pkg::item_type chain [NDIV+1];
   assign chain[0] = hf_ff[NREG-1];

   for (genvar d = 0; d < NREG - 1; d++) begin : g_div
      for (genvar s = 0; s < mrix_pkg::DIV_STAGES; s++) begin : g_stage
         mrix_div_stage #(
            .FIRST (s == 0),
            .LAST  (s == mrix_pkg::DIV_STAGES - 1),
            .DIM   (NREG - 1 - d)
         ) u_stage (
            .clock   (clock),
            .reset   (reset),
            .divisor (eff[NREG-1-d]),
            .item_i  (chain[d*mrix_pkg::DIV_STAGES+s]),
            .item_o  (chain[d*mrix_pkg::DIV_STAGES+s+1])
         );
      end
   end

   logic                                 rsp_valid_ff;
   logic [mrix_pkg::OFFSET_W-1:0]        offset_ff, offset_in;
   logic [NREG-1:0][mrix_pkg::COORD_W-1:0] coord_ff, coord_in;
   mrix_pkg::err_type                    err_ff, err_in;
   logic                                 off_nz;
   logic                                 crd_zero;
   logic                                 err_set;
   logic                                 rsp_zero;

   always_comb begin
      mrix_pkg::item_type last;
      last      = chain[NDIV];
      offset_in = '0;
      coord_in  = '0;
      err_in    = mrix_pkg::ERR_NONE;
      if (last.opcode == mrix_pkg::OP_FLATTEN) begin
         if (last.cerr) begin
            err_in = mrix_pkg::ERR_COORD;
         end else begin
            offset_in = last.acc;
         end
      end else begin
         if (last.work >= mrix_pkg::OFFSET_W'(eff[0])) begin
            err_in = mrix_pkg::ERR_OFFSET;
         end else begin
            coord_in    = last.coord;
            coord_in[0] = last.work[mrix_pkg::COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain[NDIV].valid;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      coord_ff  <= coord_in;
      err_ff    <= err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_offset_out  = offset_ff;
   assign rsp_out_coord_0 = coord_ff[0];
   assign rsp_out_coord_1 = coord_ff[1];
   assign rsp_out_coord_2 = coord_ff[2];
   assign rsp_out_coord_3 = coord_ff[3];
   assign rsp_error_code  = err_ff;

   assign off_nz   = (rsp_offset_out != '0);
   assign crd_zero = (coord_ff == '0);
   assign err_set  = (rsp_error_code != mrix_pkg::ERR_NONE);
   assign rsp_zero = !off_nz && crd_zero;

   `MRIX_ASSERT_IMPL(a_entry_from_transfer, clock, reset, hf_ff[0].valid, $past(start && !busy))
   `MRIX_ASSERT_IMPL(a_error_clears_payload, clock, reset, rsp_valid && err_set, rsp_zero)
   `MRIX_ASSERT_IMPL(a_offset_excludes_coords, clock, reset, rsp_valid && off_nz, !err_set && crd_zero)

endmodule

// ===== tb/sv/mixed_radix_index_convert_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed-radix index converter checker
// Tracks register writes, predicts each conversion from the accepted request
// and compares every response field against the oldest prediction.
// ----------------------------------------------------------------------------
module mixed_radix_index_convert_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [4:0]                     paddr,
   input  logic [31:0]                    pwdata,
   input  logic                           pready,
   input  logic                           start,
   input  logic                           busy,
   input  logic                           req_opcode,
   input  logic [mrix_pkg::COORD_W-1:0]   req_coord_0,
   input  logic [mrix_pkg::COORD_W-1:0]   req_coord_1,
   input  logic [mrix_pkg::COORD_W-1:0]   req_coord_2,
   input  logic [mrix_pkg::COORD_W-1:0]   req_coord_3,
   input  logic [mrix_pkg::OFFSET_W-1:0]  req_offset_in,
   input  logic                           rsp_valid,
   input  logic [mrix_pkg::OFFSET_W-1:0]  rsp_offset_out,
   input  logic [mrix_pkg::COORD_W-1:0]   rsp_out_coord_0,
   input  logic [mrix_pkg::COORD_W-1:0]   rsp_out_coord_1,
   input  logic [mrix_pkg::COORD_W-1:0]   rsp_out_coord_2,
   input  logic [mrix_pkg::COORD_W-1:0]   rsp_out_coord_3,
   input  logic [1:0]                     rsp_error_code,
   output int                             fail_count,
   output int                             pending_count,
   output int                             result_count
);

   typedef struct {
      logic [mrix_pkg::OFFSET_W-1:0]                      offset;
      logic [mrix_pkg::NUM_REGS-1:0][mrix_pkg::COORD_W-1:0] coord;
      mrix_pkg::err_type                                  err;
   } conversion_type;

   logic [2:0]                  dim_count_q;
   logic [mrix_pkg::SIZE_W-1:0] size_q [mrix_pkg::NUM_REGS];
   conversion_type              expected_conversions [$];

   function automatic conversion_type convert_index(
      input logic op,
      input logic [mrix_pkg::NUM_REGS-1:0][mrix_pkg::COORD_W-1:0] coord,
      input logic [mrix_pkg::OFFSET_W-1:0] offset
   );
      conversion_type   r;
      longint unsigned  sz [mrix_pkg::NUM_REGS];
      longint unsigned  stride [mrix_pkg::NUM_REGS];
      longint unsigned  vol;
      longint unsigned  sum;
      longint unsigned  off;
      longint unsigned  rem;
      int               n;
      r.offset = '0;
      r.coord = '0;
      r.err = mrix_pkg::ERR_NONE;
      n = (dim_count_q > 3'd4) ? 4 : int'(dim_count_q);
      for (int k = 0; k < mrix_pkg::NUM_REGS; k++) begin
         if (size_q[k] == '0) sz[k] = 1;
         else if (size_q[k] > 13'd4096) sz[k] = 4096;
         else sz[k] = 64'(size_q[k]);
      end
      vol = 1;
      for (int j = n - 1; j >= 0; j--) begin
         stride[j] = vol;
         vol = vol * sz[j];
      end
      if (op == mrix_pkg::OP_FLATTEN) begin
         sum = 0;
         for (int k = 0; k < n; k++) begin
            if (64'(coord[k]) >= sz[k]) begin
               r.err = mrix_pkg::ERR_COORD;
               return r;
            end
            sum += 64'(coord[k]) * stride[k];
         end
         r.offset = sum[mrix_pkg::OFFSET_W-1:0];
      end else begin
         off = 64'(offset);
         if (n == 0) begin
            if (off != 0) r.err = mrix_pkg::ERR_OFFSET;
         end else if (off / stride[0] >= sz[0]) begin
            r.err = mrix_pkg::ERR_OFFSET;
         end else begin
            for (int k = 0; k < n; k++) begin
               rem = (k == 0) ? off : off % stride[k-1];
               r.coord[k] = mrix_pkg::COORD_W'(rem / stride[k]);
            end
         end
      end
      return r;
   endfunction

   assign pending_count = expected_conversions.size();

   always @(posedge clock) begin
      conversion_type e;
      conversion_type p;
      if (reset) begin
         dim_count_q <= '0;
         for (int k = 0; k < mrix_pkg::NUM_REGS; k++) size_q[k] <= mrix_pkg::SIZE_W'(1);
         expected_conversions.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (start && !busy) begin
            p = convert_index(req_opcode,
               {req_coord_3, req_coord_2, req_coord_1, req_coord_0}, req_offset_in);
            expected_conversions.insert(expected_conversions.size(), p);
         end
         if (rsp_valid) begin
            result_count <= result_count + 1;
            if (expected_conversions.size() == 0) begin
               if (fail_count < 10) $display("unexpected transfer on the response side");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_conversions.pop_front();
               if (rsp_offset_out !== e.offset || rsp_error_code !== e.err
                   || rsp_out_coord_0 !== e.coord[0] || rsp_out_coord_1 !== e.coord[1]
                   || rsp_out_coord_2 !== e.coord[2] || rsp_out_coord_3 !== e.coord[3]) begin
                  if (fail_count < 10) begin
                     $display("bad response: expected off=%h c=%h/%h/%h/%h err=%0d",
                        e.offset, e.coord[0], e.coord[1], e.coord[2], e.coord[3], e.err);
                     $display("              actual   off=%h c=%h/%h/%h/%h err=%0d",
                        rsp_offset_out, rsp_out_coord_0, rsp_out_coord_1,
                        rsp_out_coord_2, rsp_out_coord_3, rsp_error_code);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               mrix_pkg::REG_DIM_COUNT: dim_count_q <= pwdata[2:0];
               mrix_pkg::REG_SIZE_DIM0: size_q[0] <= pwdata[mrix_pkg::SIZE_W-1:0];
               mrix_pkg::REG_SIZE_DIM1: size_q[1] <= pwdata[mrix_pkg::SIZE_W-1:0];
               mrix_pkg::REG_SIZE_DIM2: size_q[2] <= pwdata[mrix_pkg::SIZE_W-1:0];
               mrix_pkg::REG_SIZE_DIM3: size_q[3] <= pwdata[mrix_pkg::SIZE_W-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/sv/mixed_radix_index_convert_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed-radix index converter testbench
// Drives directed and random flatten and unflatten requests across a series
// of box shapes, writing the registers between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module mixed_radix_index_convert_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int COORD_W     = mrix_pkg::COORD_W;
   localparam int OFFSET_W    = mrix_pkg::OFFSET_W;
   localparam int NUM_REGS    = mrix_pkg::NUM_REGS;

   logic                 clock;
   logic                 reset;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [4:0]           paddr;
   logic [31:0]          pwdata;
   logic [31:0]          prdata;
   logic                 pready;
   logic                 start;
   logic                 busy;
   logic                 req_opcode;
   logic [COORD_W-1:0]   req_coord_0;
   logic [COORD_W-1:0]   req_coord_1;
   logic [COORD_W-1:0]   req_coord_2;
   logic [COORD_W-1:0]   req_coord_3;
   logic [OFFSET_W-1:0]  req_offset_in;
   logic                 rsp_valid;
   logic [OFFSET_W-1:0]  rsp_offset_out;
   logic [COORD_W-1:0]   rsp_out_coord_0;
   logic [COORD_W-1:0]   rsp_out_coord_1;
   logic [COORD_W-1:0]   rsp_out_coord_2;
   logic [COORD_W-1:0]   rsp_out_coord_3;
   logic [1:0]           rsp_error_code;
   int                   fail_count;
   int                   pending_count;
   int                   result_count;
   int                   cycle_count = 0;
   int                   idle_pct;
   int                   sent_count;
   int                   eff_dims;
   longint unsigned      eff_size [NUM_REGS];
   longint unsigned      box_volume;

   mixed_radix_index_convert u_top (.*);

   mixed_radix_index_convert_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("mixed_radix_index_convert: mismatch");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (45) @(negedge clock);
   endtask

   task automatic set_box(input logic [2:0] dims, input logic [12:0] s0, input logic [12:0] s1,
                          input logic [12:0] s2, input logic [12:0] s3);
      logic [12:0] s [NUM_REGS];
      drain();
      s = '{s0, s1, s2, s3};
      write_reg(mrix_pkg::REG_DIM_COUNT, 32'(dims));
      write_reg(mrix_pkg::REG_SIZE_DIM0, 32'(s0));
      write_reg(mrix_pkg::REG_SIZE_DIM1, 32'(s1));
      write_reg(mrix_pkg::REG_SIZE_DIM2, 32'(s2));
      write_reg(mrix_pkg::REG_SIZE_DIM3, 32'(s3));
      eff_dims = (dims > 3'd4) ? 4 : int'(dims);
      box_volume = 1;
      for (int k = 0; k < NUM_REGS; k++) begin
         if (s[k] == '0) eff_size[k] = 1;
         else if (s[k] > 13'd4096) eff_size[k] = 4096;
         else eff_size[k] = 64'(s[k]);
         if (k < eff_dims) box_volume = box_volume * eff_size[k];
      end
   endtask

   task automatic send(input logic op, input logic [COORD_W-1:0] c0, input logic [COORD_W-1:0] c1,
                       input logic [COORD_W-1:0] c2, input logic [COORD_W-1:0] c3,
                       input logic [OFFSET_W-1:0] off);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_coord_0 <= c0;
      req_coord_1 <= c1;
      req_coord_2 <= c2;
      req_coord_3 <= c3;
      req_offset_in <= off;
      while (busy) @(negedge clock);
      @(posedge clock);
      sent_count++;
   endtask

   function automatic logic [COORD_W-1:0] pick_coord(input int k);
      if (k >= eff_dims || $urandom_range(99) < 8) return COORD_W'($urandom);
      return COORD_W'($urandom_range(int'(eff_size[k]) - 1));
   endfunction

   task automatic send_random();
      logic [OFFSET_W-1:0] raw;
      logic [OFFSET_W-1:0] off;
      int                  pick;
      raw = OFFSET_W'({$urandom, $urandom});
      pick = $urandom_range(99);
      if (pick < 80) off = OFFSET_W'(64'(raw) % box_volume);
      else if (pick < 90) off = OFFSET_W'(box_volume - 2 + 64'($urandom_range(3)));
      else off = raw;
      send(1'($urandom_range(1)), pick_coord(0), pick_coord(1), pick_coord(2), pick_coord(3),
           off);
   endtask

   initial begin
      logic [12:0] rs [NUM_REGS];
      sent_count = 0;
      idle_pct = 0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      start = 1'b0;
      req_opcode = mrix_pkg::OP_FLATTEN;
      req_coord_0 = '0;
      req_coord_1 = '0;
      req_coord_2 = '0;
      req_coord_3 = '0;
      req_offset_in = '0;
      eff_dims = 0;
      box_volume = 1;
      for (int k = 0; k < NUM_REGS; k++) eff_size[k] = 1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Trivial box straight out of reset.
      send(mrix_pkg::OP_FLATTEN, '1, '1, '1, '1, '0);
      send(mrix_pkg::OP_UNFLATTEN, '0, '0, '0, '0, '0);
      send(mrix_pkg::OP_UNFLATTEN, '0, '0, '0, '0, 48'd1);
      send(mrix_pkg::OP_UNFLATTEN, '0, '0, '0, '0, '1);

      set_box(3'd4, 13'd4096, 13'd4096, 13'd4096, 13'd4096);
      send(mrix_pkg::OP_FLATTEN, '1, '1, '1, '1, '0);
      send(mrix_pkg::OP_FLATTEN, '0, '0, '0, '0, '1);
      send(mrix_pkg::OP_UNFLATTEN, '0, '0, '0, '0, '1);
      send(mrix_pkg::OP_UNFLATTEN, '1, '1, '1, '1, '0);
      send(mrix_pkg::OP_UNFLATTEN, '0, '0, '0, '0, 48'h123456789ABC);

      set_box(3'd4, 13'd0, 13'd8191, 13'd3, 13'd4097);
      send(mrix_pkg::OP_FLATTEN, 12'd0, 12'd4095, 12'd2, 12'd4095, '0);
      send(mrix_pkg::OP_FLATTEN, 12'd1, 12'd0, 12'd0, 12'd0, '0);
      send(mrix_pkg::OP_FLATTEN, 12'd0, 12'd0, 12'd3, 12'd0, '0);
      send(mrix_pkg::OP_UNFLATTEN, '0, '0, '0, '0, 48'd50331647);
      send(mrix_pkg::OP_UNFLATTEN, '0, '0, '0, '0, 48'd50331648);

      set_box(3'd7, 13'd5, 13'd7, 13'd9, 13'd11);
      send(mrix_pkg::OP_FLATTEN, 12'd4, 12'd6, 12'd8, 12'd10, '0);
      send(mrix_pkg::OP_FLATTEN, 12'd4, 12'd6, 12'd8, 12'd11, '0);
      send(mrix_pkg::OP_UNFLATTEN, '0, '0, '0, '0, 48'd3464);
      send(mrix_pkg::OP_UNFLATTEN, '0, '0, '0, '0, 48'd3465);

      set_box(3'd2, 13'd1, 13'd4096, 13'd1, 13'd1);
      send(mrix_pkg::OP_FLATTEN, 12'd0, 12'd4095, '1, '1, '0);
      send(mrix_pkg::OP_UNFLATTEN, '0, '0, '0, '0, 48'd4095);

      for (int phase = 0; phase < 6; phase++) begin
         for (int k = 0; k < NUM_REGS; k++) begin
            case ($urandom_range(4))
               0: rs[k] = 13'($urandom);
               1: rs[k] = 13'd4096;
               2: rs[k] = 13'd0;
               default: rs[k] = 13'($urandom_range(1, 24));
            endcase
         end
         set_box(3'($urandom_range(phase == 0 ? 4 : 0, 7)), rs[0], rs[1], rs[2], rs[3]);
         idle_pct = (phase < 2) ? 34 : ((phase < 4) ? 88 : 0);
         for (int i = 0; i < 316; i++) begin
            if (phase == 2 && i == 150) drain();
            send_random();
         end
      end

      drain();
      $display("Sent %0d requests across 11 box shapes, %0d responses checked.",
         sent_count, result_count);
      $display("Shapes included trivial, oversized, zero-size and over-count settings.");
      if (fail_count == 0) begin
         $display("mixed_radix_index_convert: match");
      end else begin
         $display("mixed_radix_index_convert: mismatch");
      end
      $finish;
   end

endmodule
